// File: design/lrps_pkg.sv
// ----------------------------------------------------------------------------
// lrps_pkg
// Shared types and constants of the latching relay power sequencer.
// ----------------------------------------------------------------------------
package lrps_pkg;

    localparam int PEND_W = 3;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_PULSE    = 2'd2;
    localparam logic [1:0] PH_STEP     = 2'd3;

    localparam logic [1:0] CFG_PULSE_TICKS    = 2'd0;
    localparam logic [1:0] CFG_STEP_TICKS     = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd2;

    localparam logic [15:0] PULSE_TICKS_RST    = 16'd15;
    localparam logic [15:0] STEP_TICKS_RST     = 16'd1000;
    localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd50;
    localparam logic [15:0] SHADOW_RST         = 16'h0000;
    localparam logic [15:0] TICK_MAX           = 16'hFFFF;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    typedef struct packed {
        logic opcode;
        logic button_level;
    } in_t;

    typedef struct packed {
        logic [15:0] expander_word;
        logic        expander_write;
        logic        pixel_write;
        logic [2:0]  pixel_index;
        logic        pixel_green;
        logic        outputs_on;
        logic        busy_res;
    } out_t;

    typedef struct packed {
        logic [15:0] pulse_ticks;
        logic [15:0] step_ticks;
        logic [7:0]  debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic [2:0]        step_index;
        logic              going_on;
        logic [15:0]       tick_count;
        logic [15:0]       shadow_word;
        logic              all_on_flag;
        logic [PEND_W-1:0] pending_events;
    } state_t;

    function automatic logic [3:0] coil_bit(input logic [2:0] idx, input logic on);
        return {idx, ~on};
    endfunction

endpackage

// File: design/latching_relay_power_sequencer.sv
// ----------------------------------------------------------------------------
// latching_relay_power_sequencer
// Sequences latching relay coils on and off from button events and ticks.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low and delivers
// its result word through an output register. All waits that end within an
// item are resolved in that same cycle by the step logic, and the sequencer
// state is updated at the accepting edge. A two-entry output buffer holds
// finished words, and input is stalled whenever its second (skid) entry is full.
module latching_relay_power_sequencer #(
    parameter int OUTPUT_COUNT = 6,
    parameter int EVENT_DEPTH  = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  lrps_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output lrps_pkg::out_t out_data
);

    lrps_pkg::cfg_t   cfg_reg;
    lrps_pkg::state_t state_reg;
    lrps_pkg::state_t state_next;
    lrps_pkg::out_t   result;
    lrps_pkg::out_t   out_reg;
    lrps_pkg::out_t   skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_acc;
    logic             out_free;

    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    lrps_step #(
        .OUTPUT_COUNT (OUTPUT_COUNT),
        .EVENT_DEPTH  (EVENT_DEPTH)
    ) u_step (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .item   (in_data),
        .nxt    (state_next),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_ticks    <= lrps_pkg::PULSE_TICKS_RST;
            cfg_reg.step_ticks     <= lrps_pkg::STEP_TICKS_RST;
            cfg_reg.debounce_ticks <= lrps_pkg::DEBOUNCE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrps_pkg::CFG_PULSE_TICKS:    cfg_reg.pulse_ticks    <= cfg_data;
                lrps_pkg::CFG_STEP_TICKS:     cfg_reg.step_ticks     <= cfg_data;
                lrps_pkg::CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data[7:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= lrps_pkg::PH_IDLE;
            state_reg.step_index     <= 3'd0;
            state_reg.going_on       <= 1'b0;
            state_reg.tick_count     <= 16'd0;
            state_reg.shadow_word    <= lrps_pkg::SHADOW_RST;
            state_reg.all_on_flag    <= 1'b0;
            state_reg.pending_events <= '0;
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_acc;
            skid_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_acc)
                out_reg <= result;
        end
        else if (in_acc)
        begin
            skid_reg <= result;
        end
    end

endmodule

// File: design/lrps_step.sv
// ----------------------------------------------------------------------------
// lrps_step
// Next state and result word for one accepted item. Every wait that ends in
// this item is resolved here, so several sequence steps may chain at once.
// ----------------------------------------------------------------------------
module lrps_step #(
    parameter int OUTPUT_COUNT = 6,
    parameter int EVENT_DEPTH  = 4
) (
    input  lrps_pkg::cfg_t   cfg,
    input  lrps_pkg::state_t cur,
    input  lrps_pkg::in_t    item,
    output lrps_pkg::state_t nxt,
    output lrps_pkg::out_t   result
);

    localparam logic [lrps_pkg::PEND_W-1:0] DEPTH    = lrps_pkg::PEND_W'(EVENT_DEPTH);
    localparam logic [lrps_pkg::PEND_W-1:0] PEND_ONE = lrps_pkg::PEND_W'(1);
    localparam logic [3:0]                  OUT_CNT  = 4'(OUTPUT_COUNT);
    localparam logic [2:0]                  LAST     = 3'(OUTPUT_COUNT - 1);

    lrps_pkg::state_t s;
    logic             wr;
    logic             pw;
    logic [2:0]       pidx;
    logic             pgreen;
    logic [15:0]      need;
    logic             act_on;
    logic             act_off;

    always_comb
    begin
        s      = cur;
        wr     = 1'b0;
        pw     = 1'b0;
        pidx   = 3'd0;
        pgreen = 1'b0;
        need   = (cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks;
        act_on  = item.button_level && !s.all_on_flag;
        act_off = !item.button_level && s.all_on_flag;

        if (item.opcode == lrps_pkg::OP_EVENT)
        begin
            if (s.pending_events < DEPTH)
                s.pending_events = s.pending_events + PEND_ONE;
        end
        else if (s.phase != lrps_pkg::PH_IDLE && s.tick_count != lrps_pkg::TICK_MAX)
        begin
            s.tick_count = s.tick_count + 16'd1;
        end

        // The coil pulse has ended: release the bit and update the pixel.
        if (s.phase == lrps_pkg::PH_PULSE && s.tick_count >= need)
        begin
            s.shadow_word = s.shadow_word &
                            ~(16'd1 << lrps_pkg::coil_bit(s.step_index, s.going_on));
            wr     = 1'b1;
            pw     = 1'b1;
            pidx   = s.step_index;
            pgreen = s.going_on;
            s.phase      = lrps_pkg::PH_STEP;
            s.tick_count = 16'd0;
        end

        // The step wait has ended: next output or end of the sequence.
        if (s.phase == lrps_pkg::PH_STEP && s.tick_count >= cfg.step_ticks)
        begin
            if (s.going_on && ({1'b0, s.step_index} + 4'd1) < OUT_CNT)
            begin
                s.step_index  = s.step_index + 3'd1;
                s.shadow_word = s.shadow_word |
                                (16'd1 << lrps_pkg::coil_bit(s.step_index, s.going_on));
                wr           = 1'b1;
                s.phase      = lrps_pkg::PH_PULSE;
                s.tick_count = 16'd0;
            end
            else if (!s.going_on && s.step_index != 3'd0)
            begin
                s.step_index  = s.step_index - 3'd1;
                s.shadow_word = s.shadow_word |
                                (16'd1 << lrps_pkg::coil_bit(s.step_index, s.going_on));
                wr           = 1'b1;
                s.phase      = lrps_pkg::PH_PULSE;
                s.tick_count = 16'd0;
            end
            else
            begin
                s.all_on_flag = s.going_on;
                s.phase       = lrps_pkg::PH_IDLE;
                s.tick_count  = 16'd0;
            end
        end

        if (s.phase == lrps_pkg::PH_IDLE && s.pending_events != '0)
        begin
            s.pending_events = s.pending_events - PEND_ONE;
            s.phase          = lrps_pkg::PH_DEBOUNCE;
            s.tick_count     = 16'd0;
        end

        act_on  = item.button_level && !s.all_on_flag;
        act_off = !item.button_level && s.all_on_flag;

        if (s.phase == lrps_pkg::PH_DEBOUNCE && s.tick_count >= {8'd0, cfg.debounce_ticks})
        begin
            if (act_on || act_off)
            begin
                s.going_on    = act_on;
                s.step_index  = act_on ? 3'd0 : LAST;
                s.shadow_word = s.shadow_word |
                                (16'd1 << lrps_pkg::coil_bit(s.step_index, s.going_on));
                wr           = 1'b1;
                s.phase      = lrps_pkg::PH_PULSE;
                s.tick_count = 16'd0;
            end
            else
            begin
                s.phase      = lrps_pkg::PH_IDLE;
                s.tick_count = 16'd0;
            end
        end

        // After a debounce with no action, further events see the same level
        // and flag, so with no debounce time they are all used up at once.
        if (s.phase == lrps_pkg::PH_IDLE && s.pending_events != '0)
        begin
            if (cfg.debounce_ticks == 8'd0)
            begin
                s.pending_events = '0;
            end
            else
            begin
                s.pending_events = s.pending_events - PEND_ONE;
                s.phase          = lrps_pkg::PH_DEBOUNCE;
                s.tick_count     = 16'd0;
            end
        end

        nxt = s;
        result.expander_word  = s.shadow_word;
        result.expander_write = wr;
        result.pixel_write    = pw;
        result.pixel_index    = pidx;
        result.pixel_green    = pgreen;
        result.outputs_on     = s.all_on_flag;
        result.busy_res       = (s.phase != lrps_pkg::PH_IDLE);
    end

endmodule

// File: design/lrps_checker.sv
// ----------------------------------------------------------------------------
// lrps_checker
// Port-level checks of the relay sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lrps_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input lrps_pkg::out_t out_data
);

    // A pixel is only updated when a coil pulse ends, which rewrites the word.
    a_pixel_has_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pixel_write |-> out_data.expander_write)
        else $error("pixel update without expander write");

    a_pixel_idle_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pixel_write |->
            out_data.pixel_index == 3'd0 && !out_data.pixel_green)
        else $error("pixel fields set without pixel write");

    // A word write without a pixel update starts a pulse, so a sequence runs.
    a_pulse_start_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_data.expander_write && !out_data.pixel_write |->
            out_data.busy_res)
        else $error("coil pulse started while not busy");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

endmodule

bind latching_relay_power_sequencer lrps_checker u_lrps_checker (.*);
